// ----- rtl/trapezoidal_pulse_shaper_unit_assert.svh -----
// Assertion macros for the trapezoidal pulse shaper unit
`ifndef TRAPEZOIDAL_PULSE_SHAPER_UNIT_ASSERT_SVH
`define TRAPEZOIDAL_PULSE_SHAPER_UNIT_ASSERT_SVH
// Check a property at every clock edge outside reset
`define TPS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("tps port check failed");
// Check a property at every clock edge, reset included
`define TPS_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
	else $error("tps port check failed during reset");
`endif

// ----- rtl/tps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and register codes of the trapezoidal pulse shaper
package tps_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PEAKING  = 3'd0,
		CFG_GAP      = 3'd1,
		CFG_GAIN_M   = 3'd2,
		CFG_GAIN_N   = 3'd3,
		CFG_BASELINE = 3'd4,
		CFG_INVERT   = 3'd5
	} cfg_index_t;

	// Register widths and reset values
	localparam int PEAK_W   = 14;
	localparam int GAP_W    = 13;
	localparam int GAIN_M_W = 16;
	localparam int GAIN_N_W = 17;
	localparam int BASE_W   = 16;
	localparam logic [PEAK_W-1:0]   PEAKING_RST = 14'd16;
	localparam logic [GAIN_M_W-1:0] GAIN_M_RST  = 16'd1;

	// Datapath widths
	localparam int RAW_W     = 16;
	localparam int SAMPLE_W  = 17;
	localparam int MIN_W     = 18;
	localparam int DIFF_W    = 19;
	localparam int SUM1_W    = 40;
	localparam int SUM2_W    = 64;
	localparam int FRAC_W    = 16;
	localparam int SPLIT_W   = 20;
	localparam int DM_W      = 36;
	localparam int PLO_W     = 37;
	localparam int PHI_W     = 38;
	localparam int SHAPED_W  = 48;
	localparam int MAX_W     = 47;
	localparam int QUO_W     = 48;
	localparam int DIVISOR_W = 14;
	localparam int LEN_W     = 17;

	typedef struct packed {
		logic [RAW_W-1:0] raw_sample;
		logic             last_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [SHAPED_W-1:0] shaped_value;
		logic [MAX_W-1:0]           running_max;
		logic                       pulse_end;
	} out_item_t;

	typedef struct packed {
		logic [PEAK_W-1:0]   peaking_length;
		logic [GAP_W-1:0]    gap_length;
		logic [GAIN_M_W-1:0] decay_gain_m;
		logic [GAIN_N_W-1:0] decay_gain_n;
		logic [BASE_W-1:0]   baseline_level;
		logic                invert_polarity;
	} cfg_t;

	// Baseline-corrected sample handed from the front to the back
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} mid_item_t;

	// Divider request and response
	typedef struct packed {
		logic                 start;
		logic [QUO_W-1:0]     dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

	// Back-end sequencer
	typedef enum logic [3:0] {
		BK_IDLE,
		BK_READ,
		BK_DIFF,
		BK_ACC1,
		BK_MUL,
		BK_COMB,
		BK_ACC2,
		BK_DIV,
		BK_WAIT,
		BK_OUT
	} back_state_t;

endpackage

// ----- rtl/tps_fifo.sv -----
`timescale 1ns / 1ps
// Two-entry request queue with registered storage
module tps_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store the incoming request
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10: begin
					count_q <= count_q + 2'd1;
				end
				2'b01: begin
					count_q <= count_q - 2'd1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

// ----- rtl/tps_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts raw samples, removes the baseline and applies polarity
module tps_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  tps_pkg::in_item_t               item,
	input  logic [tps_pkg::BASE_W-1:0]      baseline_level,
	input  logic                            invert_polarity,
	output logic                            mid_push,
	input  logic                            mid_full,
	output tps_pkg::mid_item_t              mid_item
);

	logic                                fr_valid_s1;
	tps_pkg::mid_item_t                  fr_item_s1;
	logic signed [tps_pkg::SAMPLE_W-1:0] corr;
	logic signed [tps_pkg::SAMPLE_W-1:0] adj;
	logic                                accept;

	// Subtract the baseline, then flip the sign on request
	assign corr = $signed({1'b0, item.raw_sample}) - $signed({1'b0, baseline_level});
	assign adj  = invert_polarity ? -corr : corr;

	// Stall only while the held request cannot move on
	assign full     = fr_valid_s1 && mid_full;
	assign accept   = push && !full;
	assign mid_push = fr_valid_s1 && !mid_full;
	assign mid_item = fr_item_s1;

	// Hold the corrected request until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_s1 <= 1'b0;
		end else if (accept) begin
			fr_valid_s1 <= 1'b1;
		end else if (mid_push) begin
			fr_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fr_item_s1.sample <= adj;
			fr_item_s1.last   <= item.last_sample;
		end
	end

endmodule

// ----- rtl/tps_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per clock, unsigned operands
module tps_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tps_pkg::div_req_t req,
	output tps_pkg::div_rsp_t rsp
);

	localparam int STEP_W = $clog2(tps_pkg::QUO_W);

	logic                            busy_q;
	logic                            done_q;
	logic [STEP_W-1:0]               step_q;
	logic [tps_pkg::DIVISOR_W-1:0]   rem_q;
	logic [tps_pkg::DIVISOR_W-1:0]   div_q;
	logic [tps_pkg::QUO_W-1:0]       quo_q;
	logic [tps_pkg::DIVISOR_W:0]     trial;
	logic [tps_pkg::DIVISOR_W:0]     trial_sub;
	logic                            fits;

	// Shift in the next dividend bit and try the subtraction
	assign trial     = {rem_q, quo_q[tps_pkg::QUO_W-1]};
	assign trial_sub = trial - {1'b0, div_q};
	assign fits      = (trial >= {1'b0, div_q});

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	// Count the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(tps_pkg::QUO_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			div_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[tps_pkg::DIVISOR_W-1:0] : trial[tps_pkg::DIVISOR_W-1:0];
			quo_q <= {quo_q[tps_pkg::QUO_W-2:0], fits};
		end
	end

endmodule

// ----- rtl/tps_back.sv -----
`timescale 1ns / 1ps
// Back end: delay lines, accumulators, scaling and running maximum
module tps_back #(
	parameter int DELAY_DEPTH = 16384
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [tps_pkg::PEAK_W-1:0]        peaking_length,
	input  logic [tps_pkg::GAP_W-1:0]         gap_length,
	input  logic [tps_pkg::GAIN_M_W-1:0]      decay_gain_m,
	input  logic [tps_pkg::GAIN_N_W-1:0]      decay_gain_n,
	input  logic                              mid_empty,
	output logic                              mid_pop,
	input  tps_pkg::mid_item_t                mid_item,
	output tps_pkg::div_req_t                 div_req,
	input  tps_pkg::div_rsp_t                 div_rsp,
	input  logic                              res_full,
	output logic                              res_push,
	output tps_pkg::out_item_t                res_item
);

	localparam int AW    = $clog2(DELAY_DEPTH);
	localparam int CW    = $clog2(DELAY_DEPTH + 1);
	localparam int LEN_W = tps_pkg::LEN_W;
	localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(DELAY_DEPTH);

	tps_pkg::back_state_t state_q, state_d;

	// Sequencer strobes
	logic load_en, rd_en, short_wr_en, long_wr_en;
	logic acc1_en, mul_en, comb_en, acc2_en, div_start, div_take, clear_en;

	// Delay line storage
	logic signed [tps_pkg::SAMPLE_W-1:0] short_mem [DELAY_DEPTH];
	logic signed [tps_pkg::MIN_W-1:0]    long_mem [DELAY_DEPTH];
	logic signed [tps_pkg::SAMPLE_W-1:0] short_rd_q;
	logic signed [tps_pkg::MIN_W-1:0]    long_rd_q;
	logic                                short_vld_q;
	logic                                long_vld_q;

	// Pointers and fill counts
	logic [AW-1:0]    sp_q, lp_q, sp_next, lp_next;
	logic [CW-1:0]    sfill_q, lfill_q;
	logic [LEN_W-1:0] sp_inc, lp_inc;
	logic [LEN_W-1:0] klen_raw, klen, mlen_raw, mlen;
	logic             sp_written, lp_written;

	// Item and datapath registers
	logic signed [tps_pkg::SAMPLE_W-1:0] sample_q;
	logic                                last_q;
	logic signed [tps_pkg::SAMPLE_W-1:0] kout;
	logic signed [tps_pkg::MIN_W-1:0]    mout;
	logic signed [tps_pkg::MIN_W-1:0]    min_w;
	logic signed [tps_pkg::DIFF_W-1:0]   diff2_w;
	logic signed [tps_pkg::DIFF_W-1:0]   diff2_q;
	logic [tps_pkg::SUM1_W-1:0]          first_sum_q;
	logic [tps_pkg::SUM2_W-1:0]          second_sum_q;
	logic signed [tps_pkg::DM_W-1:0]     dm_q;
	logic [tps_pkg::PLO_W-1:0]           plo_q;
	logic signed [tps_pkg::PHI_W-1:0]    phi_q;
	logic [tps_pkg::SUM2_W-1:0]          sn_q;
	logic [tps_pkg::SUM2_W-1:0]          mag;
	logic                                neg_q;
	logic [tps_pkg::SHAPED_W-1:0]        shaped_q;
	logic [tps_pkg::MAX_W-1:0]           max_q;
	logic [tps_pkg::MAX_W-1:0]           max_new;

	// Effective lengths: zero peaking acts as one, both clamp to the depth
	assign klen_raw = (peaking_length == '0) ? LEN_W'(1) : LEN_W'(peaking_length);
	assign klen     = (klen_raw > DEPTH_L) ? DEPTH_L : klen_raw;
	assign mlen_raw = klen + LEN_W'(gap_length);
	assign mlen     = (mlen_raw > DEPTH_L) ? DEPTH_L : mlen_raw;

	// Pointer advance with wrap at the current length
	assign sp_inc  = LEN_W'(sp_q) + LEN_W'(1);
	assign lp_inc  = LEN_W'(lp_q) + LEN_W'(1);
	assign sp_next = (sp_inc >= klen) ? '0 : sp_inc[AW-1:0];
	assign lp_next = (lp_inc >= mlen) ? '0 : lp_inc[AW-1:0];

	// Entries below the fill count were written since the pulse start
	assign sp_written = (CW'(sp_q) < sfill_q);
	assign lp_written = (CW'(lp_q) < lfill_q);

	// Differences of the two delay stages
	assign kout    = short_vld_q ? short_rd_q : '0;
	assign mout    = long_vld_q ? long_rd_q : '0;
	assign min_w   = {sample_q[tps_pkg::SAMPLE_W-1], sample_q} - {kout[tps_pkg::SAMPLE_W-1], kout};
	assign diff2_w = {min_w[tps_pkg::MIN_W-1], min_w} - {mout[tps_pkg::MIN_W-1], mout};

	// Magnitude of the second sum, Q16 fraction dropped before the divide
	assign mag               = second_sum_q[tps_pkg::SUM2_W-1] ? -second_sum_q : second_sum_q;
	assign div_req.start     = div_start;
	assign div_req.dividend  = mag[tps_pkg::SUM2_W-1:tps_pkg::FRAC_W];
	assign div_req.divisor   = klen[tps_pkg::DIVISOR_W-1:0];

	// Running maximum including this result
	assign max_new = ($signed(shaped_q) > $signed({1'b0, max_q})) ?
		shaped_q[tps_pkg::MAX_W-1:0] : max_q;

	assign res_item.shaped_value = $signed(shaped_q);
	assign res_item.running_max  = max_new;
	assign res_item.pulse_end    = last_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tps_pkg::BK_IDLE: begin
				if (!mid_empty) begin
					state_d = tps_pkg::BK_READ;
				end
			end
			tps_pkg::BK_READ: state_d = tps_pkg::BK_DIFF;
			tps_pkg::BK_DIFF: state_d = tps_pkg::BK_ACC1;
			tps_pkg::BK_ACC1: state_d = tps_pkg::BK_MUL;
			tps_pkg::BK_MUL:  state_d = tps_pkg::BK_COMB;
			tps_pkg::BK_COMB: state_d = tps_pkg::BK_ACC2;
			tps_pkg::BK_ACC2: state_d = tps_pkg::BK_DIV;
			tps_pkg::BK_DIV:  state_d = tps_pkg::BK_WAIT;
			tps_pkg::BK_WAIT: begin
				if (div_rsp.done) begin
					state_d = tps_pkg::BK_OUT;
				end
			end
			tps_pkg::BK_OUT: begin
				if (!res_full) begin
					state_d = tps_pkg::BK_IDLE;
				end
			end
			default: state_d = tps_pkg::BK_IDLE;
		endcase
	end

	// Strobes per state
	always_comb begin
		load_en     = 1'b0;
		rd_en       = 1'b0;
		short_wr_en = 1'b0;
		long_wr_en  = 1'b0;
		acc1_en     = 1'b0;
		mul_en      = 1'b0;
		comb_en     = 1'b0;
		acc2_en     = 1'b0;
		div_start   = 1'b0;
		div_take    = 1'b0;
		res_push    = 1'b0;
		unique case (state_q)
			tps_pkg::BK_IDLE: load_en = !mid_empty;
			tps_pkg::BK_READ: begin
				rd_en       = 1'b1;
				short_wr_en = 1'b1;
			end
			tps_pkg::BK_DIFF: long_wr_en = 1'b1;
			tps_pkg::BK_ACC1: acc1_en = 1'b1;
			tps_pkg::BK_MUL:  mul_en = 1'b1;
			tps_pkg::BK_COMB: comb_en = 1'b1;
			tps_pkg::BK_ACC2: acc2_en = 1'b1;
			tps_pkg::BK_DIV:  div_start = 1'b1;
			tps_pkg::BK_WAIT: div_take = div_rsp.done;
			tps_pkg::BK_OUT:  res_push = !res_full;
			default: begin
				load_en = 1'b0;
			end
		endcase
	end

	assign mid_pop  = load_en;
	assign clear_en = res_push && last_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tps_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Short delay line: read the old entry, write the new sample
	always_ff @(posedge clk) begin
		if (rd_en) begin
			short_rd_q  <= short_mem[sp_q];
			short_vld_q <= sp_written;
		end
		if (short_wr_en) begin
			short_mem[sp_q] <= sample_q;
		end
	end

	// Long delay line: read with the short one, write the first difference later
	always_ff @(posedge clk) begin
		if (rd_en) begin
			long_rd_q  <= long_mem[lp_q];
			long_vld_q <= lp_written;
		end
		if (long_wr_en) begin
			long_mem[lp_q] <= min_w;
		end
	end

	// Pulse state: pointers, fill counts, accumulators and maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q         <= '0;
			lp_q         <= '0;
			sfill_q      <= '0;
			lfill_q      <= '0;
			first_sum_q  <= '0;
			second_sum_q <= '0;
			max_q        <= '0;
		end else if (clear_en) begin
			sp_q         <= '0;
			lp_q         <= '0;
			sfill_q      <= '0;
			lfill_q      <= '0;
			first_sum_q  <= '0;
			second_sum_q <= '0;
			max_q        <= '0;
		end else begin
			if (short_wr_en) begin
				sp_q <= sp_next;
				if (CW'(sp_q) == sfill_q) begin
					sfill_q <= sfill_q + CW'(1);
				end
			end
			if (long_wr_en) begin
				lp_q <= lp_next;
				if (CW'(lp_q) == lfill_q) begin
					lfill_q <= lfill_q + CW'(1);
				end
			end
			if (acc1_en) begin
				first_sum_q <= first_sum_q +
					{{(tps_pkg::SUM1_W - tps_pkg::DIFF_W){diff2_q[tps_pkg::DIFF_W-1]}}, diff2_q};
			end
			if (mul_en) begin
				second_sum_q <= second_sum_q +
					{{(tps_pkg::SUM2_W - tps_pkg::DM_W - tps_pkg::FRAC_W){dm_q[tps_pkg::DM_W-1]}},
					 dm_q, {tps_pkg::FRAC_W{1'b0}}};
			end else if (acc2_en) begin
				second_sum_q <= second_sum_q + sn_q;
			end
			if (res_push) begin
				max_q <= max_new;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (load_en) begin
			sample_q <= mid_item.sample;
			last_q   <= mid_item.last;
		end
		if (long_wr_en) begin
			diff2_q <= diff2_w;
		end
		if (acc1_en) begin
			dm_q <= diff2_q * $signed({1'b0, decay_gain_m});
		end
		// Split the 40-bit first sum so each product stays narrow
		if (mul_en) begin
			plo_q <= first_sum_q[tps_pkg::SPLIT_W-1:0] * decay_gain_n;
			phi_q <= $signed(first_sum_q[tps_pkg::SUM1_W-1:tps_pkg::SPLIT_W]) *
				$signed({1'b0, decay_gain_n});
		end
		if (comb_en) begin
			sn_q <= {{(tps_pkg::SUM2_W - tps_pkg::PHI_W - tps_pkg::SPLIT_W){phi_q[tps_pkg::PHI_W-1]}},
				phi_q, {tps_pkg::SPLIT_W{1'b0}}} +
				{{(tps_pkg::SUM2_W - tps_pkg::PLO_W){1'b0}}, plo_q};
		end
		if (div_start) begin
			neg_q <= second_sum_q[tps_pkg::SUM2_W-1];
		end
		// Quotient magnitude is at most 2^47, so the signed result always fits
		if (div_take) begin
			shaped_q <= neg_q ? -div_rsp.quotient : div_rsp.quotient;
		end
	end

endmodule

// ----- rtl/trapezoidal_pulse_shaper_unit.sv -----
`timescale 1ns / 1ps
// Trapezoidal pulse shaper: top level with configuration registers and queues
//
// Each raw sample pushed in yields one result in the result queue: the
// baseline-corrected sample runs through two delay lines of DELAY_DEPTH
// entries, two accumulators with pole-zero correction, and a divide by the
// peaking length. The back end handles one sample at a time and takes the next
// one only once its result is in the result queue. The bit-serial divider
// produces one quotient bit per clock. Two-entry
// queues at the input side and the output side let the front end take new
// samples and results wait while the back end is busy. The delay lines need
// no clearing pass after reset or at a pulse end: fill counts mark which
// entries hold data of the current pulse. Configuration writes take effect on
// the next sample and are to be made while the unit is idle.
module trapezoidal_pulse_shaper_unit #(
	parameter int DELAY_DEPTH = 16384
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  tps_pkg::in_item_t                 item,
	output logic                              empty,
	input  logic                              pop,
	output tps_pkg::out_item_t                result,
	input  logic                              cfg_we,
	input  logic [tps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tps_pkg::CFG_DATA_W-1:0]    cfg_data
);

	tps_pkg::cfg_t      cfg_q;
	tps_pkg::mid_item_t fr_item;
	tps_pkg::mid_item_t mid_head;
	tps_pkg::out_item_t res_item;
	tps_pkg::div_req_t  div_req;
	tps_pkg::div_rsp_t  div_rsp;
	logic               mid_push;
	logic               mid_full;
	logic               mid_pop;
	logic               mid_empty;
	logic               res_push;
	logic               res_full;
	logic [$bits(tps_pkg::mid_item_t)-1:0] mid_rdata;
	logic [$bits(tps_pkg::out_item_t)-1:0] res_rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peaking_length  <= tps_pkg::PEAKING_RST;
			cfg_q.gap_length      <= '0;
			cfg_q.decay_gain_m    <= tps_pkg::GAIN_M_RST;
			cfg_q.decay_gain_n    <= '0;
			cfg_q.baseline_level  <= '0;
			cfg_q.invert_polarity <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tps_pkg::CFG_PEAKING:  cfg_q.peaking_length  <= cfg_data[tps_pkg::PEAK_W-1:0];
				tps_pkg::CFG_GAP:      cfg_q.gap_length      <= cfg_data[tps_pkg::GAP_W-1:0];
				tps_pkg::CFG_GAIN_M:   cfg_q.decay_gain_m    <= cfg_data[tps_pkg::GAIN_M_W-1:0];
				tps_pkg::CFG_GAIN_N:   cfg_q.decay_gain_n    <= cfg_data[tps_pkg::GAIN_N_W-1:0];
				tps_pkg::CFG_BASELINE: cfg_q.baseline_level  <= cfg_data[tps_pkg::BASE_W-1:0];
				tps_pkg::CFG_INVERT:   cfg_q.invert_polarity <= cfg_data[0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Front end
	tps_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.item            (item),
		.baseline_level  (cfg_q.baseline_level),
		.invert_polarity (cfg_q.invert_polarity),
		.mid_push        (mid_push),
		.mid_full        (mid_full),
		.mid_item        (fr_item)
	);

	// Queue between front and back
	tps_fifo #(
		.WIDTH ($bits(tps_pkg::mid_item_t))
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.full   (mid_full),
		.wdata  (fr_item),
		.pop    (mid_pop),
		.empty  (mid_empty),
		.rdata  (mid_rdata)
	);

	assign mid_head = tps_pkg::mid_item_t'(mid_rdata);

	// Back end
	tps_back #(
		.DELAY_DEPTH (DELAY_DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.peaking_length (cfg_q.peaking_length),
		.gap_length     (cfg_q.gap_length),
		.decay_gain_m   (cfg_q.decay_gain_m),
		.decay_gain_n   (cfg_q.decay_gain_n),
		.mid_empty      (mid_empty),
		.mid_pop        (mid_pop),
		.mid_item       (mid_head),
		.div_req        (div_req),
		.div_rsp        (div_rsp),
		.res_full       (res_full),
		.res_push       (res_push),
		.res_item       (res_item)
	);

	// Output scaling divider
	tps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Result queue
	tps_fifo #(
		.WIDTH ($bits(tps_pkg::out_item_t))
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_item),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_rdata)
	);

	assign result = tps_pkg::out_item_t'(res_rdata);

endmodule

// ----- rtl/tps_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the trapezoidal pulse shaper unit and their binding
`include "trapezoidal_pulse_shaper_unit_assert.svh"

module tps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input tps_pkg::out_item_t result
);

	logic [tps_pkg::MAX_W-1:0] prev_max_q;
	logic                      prev_end_q;
	logic                      res_take;

	assign res_take = pop && !empty;

	// Remember the maximum and pulse end of the last request taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_max_q <= '0;
			prev_end_q <= 1'b1;
		end else if (res_take) begin
			prev_max_q <= result.running_max;
			prev_end_q <= result.pulse_end;
		end
	end

	// Nothing waits and nothing stalls while in reset
	`TPS_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> empty && !full)

	// The running maximum covers the value it travels with
	`TPS_ASSERT(a_max_covers, !empty |-> $signed(result.shaped_value) <= $signed({1'b0, result.running_max}))

	// Within a pulse the maximum never drops
	`TPS_ASSERT(a_max_grows, res_take && !prev_end_q |-> result.running_max >= prev_max_q)

	// A waiting result holds until taken
	`TPS_ASSERT(a_result_holds, !empty && !pop |=> !empty && $stable(result))

endmodule

bind trapezoidal_pulse_shaper_unit tps_checker u_tps_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
